/* rtl/length_prefixed_frame_deframer_macros.svh */
// Assertion macros for the length-prefixed frame deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LPFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lpfd_pkg.sv */
// Types and constants shared by the deframer files.
package lpfd_pkg;

  localparam int unsigned HdrBytes   = 6;
  localparam int unsigned MaxLenW    = 25;
  localparam logic [MaxLenW-1:0] MaxLenReset = 25'd65536;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_BIG   = 2'd2,
    KIND_SMALL = 2'd3
  } kind_t;

  typedef enum logic {
    ST_HEADER  = 1'b0,
    ST_PAYLOAD = 1'b1
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] frame_type;
    logic [7:0]  payload_byte;
    logic        last;
    logic [31:0] frame_len;
  } out_item_t;

  typedef logic [MaxLenW-1:0] max_len_t;

  // Input register contents seen by the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } in_stage_t;

  // Parser result for the item in the input register.
  typedef struct packed {
    logic      has_res;
    out_item_t item;
  } parse_res_t;

endpackage

/* rtl/lpfd_stream_if.sv */
// Valid/ready channel carrying one item of a given payload type.
interface lpfd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/lpfd_in_stage.sv */
// Input register: captures one byte item and holds it until the parser advances.
module lpfd_in_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  lpfd_pkg::in_item_t   in_data,
  output logic                 in_ready,
  input  logic                 adv,
  output lpfd_pkg::in_stage_t  stage
);

  logic       valid;
  logic [7:0] data_byte;

  assign in_ready = !valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_byte <= in_data.data_byte;
    end
  end

  assign stage.valid     = valid;
  assign stage.data_byte = data_byte;

endmodule

/* rtl/lpfd_parse.sv */
// Frame parser: header collection, length check and payload countdown.
module lpfd_parse (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [7:0]            data_byte,
  input  lpfd_pkg::max_len_t    max_len,
  output lpfd_pkg::parse_res_t  res
);

  lpfd_pkg::parse_state_t state, state_next;
  logic [2:0]  header_count, header_count_next;
  logic [47:0] header_shift, header_shift_next;
  logic [31:0] payload_left, payload_left_next;

  logic [31:0] len;
  logic [31:0] pl_dec;

  assign header_shift_next = (state == lpfd_pkg::ST_HEADER) ?
                             {header_shift[39:0], data_byte} : header_shift;
  assign len    = header_shift_next[47:16];
  assign pl_dec = payload_left - 32'd1;

  always_comb begin
    state_next        = state;
    header_count_next = header_count;
    payload_left_next = payload_left;
    res.has_res            = 1'b0;
    res.item.kind          = lpfd_pkg::KIND_DATA;
    res.item.frame_type    = header_shift_next[15:0];
    res.item.payload_byte  = 8'd0;
    res.item.last          = 1'b1;
    res.item.frame_len     = len;
    unique case (state)
      lpfd_pkg::ST_PAYLOAD: begin
        payload_left_next     = pl_dec;
        res.has_res           = 1'b1;
        res.item.payload_byte = data_byte;
        res.item.last         = (pl_dec == 32'd0);
        if (pl_dec == 32'd0) begin
          state_next = lpfd_pkg::ST_HEADER;
        end
      end
      lpfd_pkg::ST_HEADER: begin
        if (header_count != 3'(lpfd_pkg::HdrBytes - 1)) begin
          header_count_next = header_count + 3'd1;
        end else begin
          header_count_next = 3'd0;
          // Too-large wins over too-small when both limits are broken.
          priority if (len > {7'd0, max_len}) begin
            res.has_res   = 1'b1;
            res.item.kind = lpfd_pkg::KIND_BIG;
          end else if (len < 32'(lpfd_pkg::HdrBytes)) begin
            res.has_res   = 1'b1;
            res.item.kind = lpfd_pkg::KIND_SMALL;
          end else if (len == 32'(lpfd_pkg::HdrBytes)) begin
            res.has_res   = 1'b1;
            res.item.kind = lpfd_pkg::KIND_EMPTY;
          end else begin
            payload_left_next = len - 32'(lpfd_pkg::HdrBytes);
            state_next        = lpfd_pkg::ST_PAYLOAD;
          end
        end
      end
      default: begin
        state_next = lpfd_pkg::ST_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lpfd_pkg::ST_HEADER;
      header_count <= 3'd0;
      header_shift <= 48'd0;
      payload_left <= 32'd0;
    end else if (adv) begin
      state        <= state_next;
      header_count <= header_count_next;
      header_shift <= header_shift_next;
      payload_left <= payload_left_next;
    end
  end

endmodule

/* rtl/length_prefixed_frame_deframer.sv */
// Top level of the length-prefixed frame deframer.
//
//  channel  dir  payload                                           item
//  din      in   data_byte[7:0]                                    one stream byte
//  dout     out  kind, frame_type, payload_byte, last, frame_len   one result
//  cfg      in   max_total_len[24:0]                               register write
//
// One byte item per cycle sustained while dout is ready; a result passes the input and result registers.
// The path is input register, parser logic (parallel 32-bit compares), result register.
// Header bytes and a good header with payload produce no result item.
// Reset clears the parser state and valid flags and sets max_total_len to 65536; cfg is always ready.
// A stalled dout holds the result; din keeps accepting while the input register can drain.
module length_prefixed_frame_deframer (
  input logic          clk,
  input logic          rst,
  lpfd_stream_if.sink   din,
  lpfd_stream_if.source dout,
  lpfd_stream_if.sink   cfg
);

  `include "length_prefixed_frame_deframer_macros.svh"

  lpfd_pkg::in_stage_t  stage;
  lpfd_pkg::parse_res_t pres;
  lpfd_pkg::max_len_t   max_len;
  lpfd_pkg::out_item_t  res_q;
  lpfd_pkg::in_item_t   din_item;
  logic                 din_ready;
  logic                 res_v;
  logic                 adv;

  assign din_item  = din.data;
  assign din.ready = din_ready;

  // Advance the parser when the input register holds a byte and the result register is free or being drained.
  assign adv = stage.valid && (!res_v || dout.ready);

  lpfd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_data  (din_item),
    .in_ready (din_ready),
    .adv      (adv),
    .stage    (stage)
  );

  lpfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .data_byte (stage.data_byte),
    .max_len   (max_len),
    .res       (pres)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= lpfd_pkg::MaxLenReset;
    end else if (cfg.valid) begin
      max_len <= lpfd_pkg::max_len_t'(cfg.data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (adv) begin
      res_v <= pres.has_res;
    end else if (dout.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pres.has_res) begin
      res_q <= pres.item;
    end
  end

  assign dout.valid = res_v;
  assign dout.data  = res_q;

  `LPFD_ASSERT_SAME(a_ctrl_last, clk, rst,
    res_v && (res_q.kind != lpfd_pkg::KIND_DATA), res_q.last,
    "empty or error result without last")
  `LPFD_ASSERT_SAME(a_ctrl_zero, clk, rst,
    res_v && (res_q.kind != lpfd_pkg::KIND_DATA), res_q.payload_byte == 8'd0,
    "nonzero byte on empty or error result")
  `LPFD_ASSERT_NEXT(a_stage_hold, clk, rst,
    stage.valid && !adv, stage.valid && $stable(stage.data_byte),
    "input register lost a stalled item")

endmodule
